// ===== design/msp_response_frame_parser_unit_assert.svh =====
// Assertion macros shared by the frame parser RTL.
`ifndef MSP_RESPONSE_FRAME_PARSER_UNIT_ASSERT_SVH
`define MSP_RESPONSE_FRAME_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

// ===== design/msp_pkg.sv =====
package msp_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_M      = 8'h4D;
  localparam logic [7:0] CHAR_GT     = 8'h3E;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DOLLAR,
    PH_M,
    PH_SIZE,
    PH_CMD,
    PH_DATA
  } msp_phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic       checksum_ok;
  } msp_result_t;

  typedef struct packed {
    logic out_full;
    logic skid_full;
  } msp_buf_status_t;

endpackage

// ===== design/msp_response_frame_parser_unit.sv =====
// Channel   Direction  Handshake                Payload
// input     in         in_valid / in_ready      rx_byte
// result    out        out_valid / out_ready    kind, payload_byte, byte_index,
//                                               frame_command, frame_length,
//                                               checksum_ok
// config    in         cfg_wr_en                cfg_wr_data (max_payload)
//
// One byte is taken every cycle while in_ready is high; its result, if any, is
// registered into the buffer's output entry, or into its skid entry while that is held.
// A two-entry output buffer takes one more result while out_ready is low.
// in_ready drops only when both buffer entries hold undelivered results.
// Reset is synchronous; it clears the parser to idle and sets max_payload to 255.
`include "msp_response_frame_parser_unit_assert.svh"

module msp_response_frame_parser_unit
  import msp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic [7:0] byte_index,
  output logic [7:0] frame_command,
  output logic [7:0] frame_length,
  output logic       checksum_ok
);

  logic            accept;
  logic            res_valid;
  msp_result_t     res;
  msp_result_t     out_data;
  msp_buf_status_t buf_status;
  logic            payload_res;
  logic            last_drain;

  assign accept = in_valid && in_ready;

  msp_frame_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  msp_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (buf_status)
  );

  assign kind          = out_data.kind;
  assign payload_byte  = out_data.payload_byte;
  assign byte_index    = out_data.byte_index;
  assign frame_command = out_data.frame_command;
  assign frame_length  = out_data.frame_length;
  assign checksum_ok   = out_data.checksum_ok;

  assign payload_res = res_valid && (res.kind == KIND_PAYLOAD);
  assign last_drain  = out_valid && out_ready && !buf_status.skid_full && !res_valid;

  `MSP_ASSERT_SAME(a_skid_behind_out, buf_status.skid_full, buf_status.out_full)
  `MSP_ASSERT_SAME(a_index_in_frame, payload_res, res.byte_index < res.frame_length)
  `MSP_ASSERT_NEXT(a_drain_empties, last_drain, !out_valid)

endmodule

// ===== design/msp_frame_fsm.sv =====
module msp_frame_fsm
  import msp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output msp_result_t res
);

  msp_phase_t phase, phase_next;
  logic [7:0] max_payload;
  logic [7:0] expected_length, expected_length_next;
  logic [7:0] held_command, held_command_next;
  logic [7:0] running_checksum, running_checksum_next;
  logic [7:0] payload_count, payload_count_next;
  logic       in_payload;

  assign in_payload = payload_count < expected_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      expected_length  <= '0;
      held_command     <= '0;
      running_checksum <= '0;
      payload_count    <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      expected_length  <= expected_length_next;
      held_command     <= held_command_next;
      running_checksum <= running_checksum_next;
      payload_count    <= payload_count_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    expected_length_next  = expected_length;
    held_command_next     = held_command;
    running_checksum_next = running_checksum;
    payload_count_next    = payload_count;
    case (phase)
      PH_IDLE: begin
        phase_next = (rx_byte == CHAR_DOLLAR) ? PH_DOLLAR : PH_IDLE;
      end
      PH_DOLLAR: begin
        phase_next = (rx_byte == CHAR_M) ? PH_M : PH_IDLE;
      end
      PH_M: begin
        phase_next = (rx_byte == CHAR_GT) ? PH_SIZE : PH_IDLE;
      end
      PH_SIZE: begin
        if (rx_byte > max_payload) begin
          phase_next = PH_IDLE;
        end else begin
          expected_length_next  = rx_byte;
          payload_count_next    = '0;
          running_checksum_next = rx_byte;
          phase_next            = PH_CMD;
        end
      end
      PH_CMD: begin
        held_command_next     = rx_byte;
        running_checksum_next = running_checksum ^ rx_byte;
        phase_next            = PH_DATA;
      end
      PH_DATA: begin
        if (in_payload) begin
          running_checksum_next = running_checksum ^ rx_byte;
          payload_count_next    = payload_count + 8'd1;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid         = accept && (phase == PH_DATA);
    res.frame_command = held_command;
    res.frame_length  = expected_length;
    if (in_payload) begin
      res.kind         = KIND_PAYLOAD;
      res.payload_byte = rx_byte;
      res.byte_index   = payload_count;
      res.checksum_ok  = 1'b0;
    end else begin
      res.kind         = KIND_FRAME_END;
      res.payload_byte = '0;
      res.byte_index   = '0;
      res.checksum_ok  = running_checksum == rx_byte;
    end
  end

endmodule

// ===== design/msp_out_skid.sv =====
module msp_out_skid
  import msp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  msp_result_t     push_data,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output msp_result_t     out_data,
  output msp_buf_status_t status
);

  logic        out_full;
  logic        skid_full;
  msp_result_t skid_data;
  logic        out_fire;

  assign out_fire  = out_full && out_ready;
  assign in_ready  = !skid_full;
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_fire) begin
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (!out_full || out_fire) begin
        out_full <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (out_fire) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_full || out_fire) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

  always_comb begin
    status.out_full  = out_full;
    status.skid_full = skid_full;
  end

endmodule

// ===== test/msp_response_frame_parser_unit_tb.sv =====
module msp_response_frame_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1620;
  localparam int SETTLE_CYCLES = 6;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic [7:0] frame_command;
  logic [7:0] frame_length;
  logic       checksum_ok;

  msp_response_frame_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .payload_byte  (payload_byte),
    .byte_index    (byte_index),
    .frame_command (frame_command),
    .frame_length  (frame_length),
    .checksum_ok   (checksum_ok)
  );

  always #1 clk = ~clk;

  // Parser state mirrored by the testbench.
  msp_phase_t  parse_state = PH_IDLE;
  logic [7:0]  size_limit = MAX_PAYLOAD_RESET;
  logic [7:0]  frame_size = 8'h00;
  logic [7:0]  frame_cmd = 8'h00;
  logic [7:0]  frame_xor = 8'h00;
  logic [7:0]  data_seen = 8'h00;
  msp_result_t expected_results[$];

  int cycles = 0;
  int errors = 0;
  int bytes_sent = 0;
  int payload_checked = 0;
  int frame_ends_checked = 0;
  int settings_used = 0;
  int burst_left = 0;
  int ready_mode = 0;

  function automatic void parse_byte(input logic [7:0] b);
    msp_result_t r;
    case (parse_state)
      PH_IDLE: parse_state = (b == CHAR_DOLLAR) ? PH_DOLLAR : PH_IDLE;
      PH_DOLLAR: parse_state = (b == CHAR_M) ? PH_M : PH_IDLE;
      PH_M: parse_state = (b == CHAR_GT) ? PH_SIZE : PH_IDLE;
      PH_SIZE: begin
        if (b > size_limit) begin
          parse_state = PH_IDLE;
        end else begin
          frame_size = b;
          data_seen = 8'h00;
          frame_xor = b;
          parse_state = PH_CMD;
        end
      end
      PH_CMD: begin
        frame_cmd = b;
        frame_xor = frame_xor ^ b;
        parse_state = PH_DATA;
      end
      PH_DATA: begin
        r.frame_command = frame_cmd;
        r.frame_length = frame_size;
        if (data_seen < frame_size) begin
          r.kind = KIND_PAYLOAD;
          r.payload_byte = b;
          r.byte_index = data_seen;
          r.checksum_ok = 1'b0;
          frame_xor = frame_xor ^ b;
          data_seen = data_seen + 8'd1;
        end else begin
          r.kind = KIND_FRAME_END;
          r.payload_byte = 8'h00;
          r.byte_index = 8'h00;
          r.checksum_ok = (frame_xor == b);
          parse_state = PH_IDLE;
        end
        expected_results.push_back(r);
      end
      default: parse_state = PH_IDLE;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    msp_result_t r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction, kind %0d, command %0d", $time,
                   kind, frame_command);
          errors++;
        end else begin
          r = expected_results.pop_front();
          check_field("kind", 8'(r.kind), 8'(kind));
          check_field("payload_byte", r.payload_byte, payload_byte);
          check_field("byte_index", r.byte_index, byte_index);
          check_field("frame_command", r.frame_command, frame_command);
          check_field("frame_length", r.frame_length, frame_length);
          check_field("checksum_ok", 8'(r.checksum_ok), 8'(checksum_ok));
          if (r.kind == KIND_PAYLOAD) payload_checked++;
          else frame_ends_checked++;
        end
      end
      if (cfg_wr_en) size_limit = cfg_wr_data;
      if (in_valid && in_ready) parse_byte(rx_byte);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycles % 64 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycles % 8 < 5);
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max(input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic send_header();
    send_byte(CHAR_DOLLAR);
    send_byte(CHAR_M);
    send_byte(CHAR_GT);
  endtask

  task automatic send_frame(input int len, input logic [7:0] cmd, input bit corrupt,
                            input bit truncate);
    logic [7:0] sum;
    logic [7:0] b;
    int         stop_at;
    send_header();
    send_byte(8'(len));
    send_byte(cmd);
    sum = 8'(len) ^ cmd;
    stop_at = truncate ? len / 2 : len;
    for (int i = 0; i < stop_at; i++) begin
      b = 8'($urandom_range(0, 255));
      sum = sum ^ b;
      send_byte(b);
    end
    if (!truncate) send_byte(corrupt ? 8'($urandom_range(0, 255)) : sum);
  endtask

  task automatic send_random_sequence(input int max_cfg);
    int         choice;
    int         len;
    logic [7:0] b;
    choice = $urandom_range(0, 19);
    if (choice == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else if (choice == 1) begin
      send_byte(CHAR_DOLLAR);
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0) begin
        send_byte(CHAR_M);
        if (b == CHAR_GT) b = 8'h00;
      end else if (b == CHAR_M) begin
        b = 8'hFF;
      end
      send_byte(b);
    end else if (choice == 2 && max_cfg < 255) begin
      send_header();
      send_byte(8'($urandom_range(max_cfg + 1, 255)));
    end else begin
      if ($urandom_range(0, 15) == 0) len = $urandom_range(0, max_cfg);
      else len = $urandom_range(0, (max_cfg < 12) ? max_cfg : 12);
      send_frame(len, 8'($urandom_range(0, 255)), choice == 4 || choice == 5, choice == 3);
    end
  endtask

  task automatic test_directed_cases();
    logic [7:0] seq[$];
    seq = '{CHAR_DOLLAR, CHAR_M, CHAR_GT, 8'h00, 8'hFF, 8'hFF,
            CHAR_DOLLAR, CHAR_DOLLAR, CHAR_M,
            CHAR_DOLLAR, CHAR_M, CHAR_M,
            CHAR_DOLLAR, CHAR_M, CHAR_GT};
    foreach (seq[i]) send_byte(seq[i]);
    wait_quiet();
    write_max(8'd2);
    send_byte(8'h03);
    seq = '{CHAR_DOLLAR, CHAR_M, CHAR_GT, 8'h02, 8'h00, 8'hFF, 8'h80, 8'h7C};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_random_frames();
    int limits[6];
    int target;
    limits = '{255, 0, 1, 7, $urandom_range(2, 254), 255};
    foreach (limits[p]) begin
      wait_quiet();
      write_max(8'(limits[p]));
      target = bytes_sent + RANDOM_BYTES / 6;
      while (bytes_sent < target) begin
        send_random_sequence(limits[p]);
        if (p == 3 && bytes_sent >= target - RANDOM_BYTES / 12 &&
            bytes_sent < target - RANDOM_BYTES / 12 + 8)
          wait_quiet();
      end
    end
  endtask

  task automatic test_longest_frame();
    wait_quiet();
    write_max(MAX_PAYLOAD_RESET);
    send_frame(255, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
    send_frame(0, 8'h00, 1'b0, 1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_frames();
    test_longest_frame();
    wait_quiet();
    $display("Sent %0d bytes; checked %0d payload bytes and %0d frame ends.", bytes_sent,
             payload_checked, frame_ends_checked);
    $display("Used %0d max_payload settings under random input gaps and output stalls.",
             settings_used);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
